@@ design/psfp_pkg.sv @@
package psfp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned PM_W    = 16;
    localparam int unsigned TDATA_W = 56;
    localparam int unsigned TUSER_W = 2;

    // header bytes and frame layout
    localparam logic [BYTE_W-1:0] HDR_0 = 8'h16;
    localparam logic [BYTE_W-1:0] HDR_1 = 8'h35;
    localparam logic [BYTE_W-1:0] HDR_2 = 8'h0B;

    localparam logic [POS_W-1:0] POS_HDR_0   = 6'd0;
    localparam logic [POS_W-1:0] POS_HDR_1   = 6'd1;
    localparam logic [POS_W-1:0] POS_HDR_2   = 6'd2;
    localparam logic [POS_W-1:0] POS_PM1_HI  = 6'd5;
    localparam logic [POS_W-1:0] POS_PM1_LO  = 6'd6;
    localparam logic [POS_W-1:0] POS_PM25_HI = 6'd9;
    localparam logic [POS_W-1:0] POS_PM25_LO = 6'd10;
    localparam logic [POS_W-1:0] POS_PM10_HI = 6'd13;
    localparam logic [POS_W-1:0] POS_PM10_LO = 6'd14;
    localparam logic [POS_W-1:0] POS_LAST    = 6'd55;

    typedef struct packed {
        logic [PM_W-1:0]  pm10_value;
        logic [PM_W-1:0]  pm25_value;
        logic [PM_W-1:0]  pm1_value;
        logic             values_updated;
        logic             checksum_good;
        logic             frame_end;
        logic [POS_W-1:0] next_position;
    } t_result;

endpackage

@@ design/psfp_parse.sv @@
module psfp_parse (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [psfp_pkg::BYTE_W-1:0] i_byte,
    output psfp_pkg::t_result          o_result
);
    import psfp_pkg::*;

    logic [POS_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [PM_W-1:0]   r_cap_small, n_cap_small;
    logic [PM_W-1:0]   r_cap_mid, n_cap_mid;
    logic [PM_W-1:0]   r_cap_large, n_cap_large;
    logic [PM_W-1:0]   r_pm1, n_pm1;
    logic [PM_W-1:0]   r_pm25, n_pm25;
    logic [PM_W-1:0]   r_pm10, n_pm10;

    logic              drop;
    logic              at_end;
    logic              good;
    logic              ordered;
    logic [BYTE_W-1:0] expect_sum;

    assign drop = ((r_pos == POS_HDR_0) && (i_byte != HDR_0))
               || ((r_pos == POS_HDR_1) && (i_byte != HDR_1))
               || ((r_pos == POS_HDR_2) && (i_byte != HDR_2));
    assign at_end     = (r_pos >= POS_LAST);
    assign expect_sum = BYTE_W'(~r_sum + 1'b1);
    assign good       = !drop && at_end && (expect_sum == i_byte);
    assign ordered    = (r_cap_small <= r_cap_mid) && (r_cap_mid <= r_cap_large);

    always_comb begin
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_cap_small = r_cap_small;
        n_cap_mid   = r_cap_mid;
        n_cap_large = r_cap_large;
        n_pm1       = r_pm1;
        n_pm25      = r_pm25;
        n_pm10      = r_pm10;
        if (drop) begin
            n_pos = '0;
        end else if (at_end) begin
            n_pos = '0;
            if (good && ordered) begin
                n_pm1  = r_cap_small;
                n_pm25 = r_cap_mid;
                n_pm10 = r_cap_large;
            end
        end else begin
            n_pos = r_pos + 1'b1;
            n_sum = (r_pos == POS_HDR_0) ? i_byte : BYTE_W'(r_sum + i_byte);
            case (r_pos)
                POS_PM1_HI:  n_cap_small = {i_byte, r_cap_small[BYTE_W-1:0]};
                POS_PM1_LO:  n_cap_small = {r_cap_small[PM_W-1:BYTE_W], i_byte};
                POS_PM25_HI: n_cap_mid   = {i_byte, r_cap_mid[BYTE_W-1:0]};
                POS_PM25_LO: n_cap_mid   = {r_cap_mid[PM_W-1:BYTE_W], i_byte};
                POS_PM10_HI: n_cap_large = {i_byte, r_cap_large[BYTE_W-1:0]};
                POS_PM10_LO: n_cap_large = {r_cap_large[PM_W-1:BYTE_W], i_byte};
                default: ;
            endcase
        end
    end

    always_comb begin
        o_result.next_position  = n_pos;
        o_result.frame_end      = !drop && at_end;
        o_result.checksum_good  = good;
        o_result.values_updated = good && ordered;
        o_result.pm1_value      = n_pm1;
        o_result.pm25_value     = n_pm25;
        o_result.pm10_value     = n_pm10;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sum       <= '0;
            r_cap_small <= '0;
            r_cap_mid   <= '0;
            r_cap_large <= '0;
            r_pm1       <= '0;
            r_pm25      <= '0;
            r_pm10      <= '0;
        end else if (i_step) begin
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_cap_small <= n_cap_small;
            r_cap_mid   <= n_cap_mid;
            r_cap_large <= n_cap_large;
            r_pm1       <= n_pm1;
            r_pm25      <= n_pm25;
            r_pm10      <= n_pm10;
        end
    end

endmodule

@@ design/particle_sensor_frame_parser.sv @@
// channel   dir  fields
// s_axis    in   tdata[7:0] rx_byte
// m_axis    out  tdata[5:0] next_position, [21:6] pm1, [37:22] pm25,
//                [53:38] pm10, [55:54] zero; tlast frame_end;
//                tuser[0] checksum_good, tuser[1] values_updated
//
// one word in, one word out, one word per cycle sustained while m_axis is ready
// each word passes the input register, then the parse step into the result register
// the frame state advances only when a word moves from the input register
// into the result register, so a stall on m_axis holds the frame state and result word in place
// synchronous active-low reset clears the frame state, held readings and
// both valid flags
module particle_sensor_frame_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [psfp_pkg::BYTE_W-1:0]   s_axis_tdata,  // [7:0] rx_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [5:0] next_position, [21:6] pm1_value, [37:22] pm25_value,
    // [53:38] pm10_value, [55:54] zero
    output logic [psfp_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                          m_axis_tlast,  // frame_end
    // [0] checksum_good, [1] values_updated
    output logic [psfp_pkg::TUSER_W-1:0]  m_axis_tuser
);
    import psfp_pkg::*;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // result register
    logic              r_out_valid;
    t_result           r_out;

    t_result           step_result;
    logic              out_free;
    logic              step;

    // result register can take a new word when empty or being drained
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    psfp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
        if (step) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.pm10_value, r_out.pm25_value,
                            r_out.pm1_value, r_out.next_position};
    assign m_axis_tlast  = r_out.frame_end;
    assign m_axis_tuser  = {r_out.values_updated, r_out.checksum_good};

endmodule

@@ design/psfp_checker.sv @@
module psfp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [psfp_pkg::BYTE_W-1:0]  s_axis_tdata,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [psfp_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic                         m_axis_tlast,
    input logic [psfp_pkg::TUSER_W-1:0] m_axis_tuser
);
    import psfp_pkg::*;

    // a frame end always sends the position back to the header
    a_end_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[POS_W-1:0] == '0))
        else $error("frame end with nonzero next position");

    // readings stored only on a good checksum, good checksum only at frame end
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((!m_axis_tuser[1] || m_axis_tuser[0])
                        && (!m_axis_tuser[0] || m_axis_tlast)))
        else $error("result flags inconsistent");

    // nothing comes out in the cycle after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid straight after reset");

    // a stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser)))
        else $error("stalled result word changed");

    // an offered input word waits unchanged until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && !s_axis_tready) |=>
            (s_axis_tvalid && $stable(s_axis_tdata)))
        else $error("offered input word changed before it was taken");

endmodule

bind particle_sensor_frame_parser psfp_checker u_psfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
